>>> sv/h264rtp_pkg.sv
`timescale 1ns / 1ps
package h264rtp_pkg;

  localparam int LenWidthDefault = 16;

  localparam int RtpHdrLen = 12;
  localparam int FuHdrLen  = 14;
  localparam int RunIdxW   = 4;

  localparam logic [7:0] RtpVersionByte = 8'h80;
  localparam logic [7:0] NalNriMask     = 8'hE0;
  localparam logic [7:0] NalTypeMask    = 8'h1F;
  localparam logic [7:0] FuATypeCode    = 8'd28;
  localparam logic [7:0] FuStartBit     = 8'h80;
  localparam logic [7:0] FuEndBit       = 8'h40;

  localparam logic [6:0]  PayloadTypeReset = 7'd96;
  localparam logic [31:0] SsrcReset        = 32'd0;
  localparam logic [15:0] MaxPayloadReset  = 16'd1200;

  localparam int          CfgAddrW   = 4;
  localparam logic [1:0]  RegPayloadType = 2'd0;
  localparam logic [1:0]  RegSsrc        = 2'd1;
  localparam logic [1:0]  RegMaxPayload  = 2'd2;

  typedef struct packed {
    logic [7:0]  nal_byte;
    logic [15:0] nal_length;
    logic [31:0] frame_time;
    logic        first_of_nal;
  } nal_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_start;
    logic       packet_end;
    logic       last_of_run;
  } pkt_out_t;

  // One run of output bytes caused by a single input byte.
  typedef struct packed {
    logic [RunIdxW-1:0] n_hdr;
    logic               marker;
    logic [15:0]        seq;
    logic [31:0]        stamp;
    logic [7:0]         fu_ind;
    logic [7:0]         fu_hdr;
    logic [7:0]         data;
    logic               pkt_end;
  } run_t;

endpackage

>>> sv/h264rtp_emit.sv
`timescale 1ns / 1ps
module h264rtp_emit import h264rtp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        run_valid_i,
  input  run_t        run_i,
  output logic        run_stall_o,
  input  logic [6:0]  payload_type_i,
  input  logic [31:0] ssrc_i,
  output logic        out_valid_o,
  output pkt_out_t    out_data_o,
  input  logic        out_stall_i
);

  logic               run_valid_q;
  run_t               run_q;
  logic [RunIdxW-1:0] idx_q;
  logic               out_valid_q;
  pkt_out_t           out_q;
  logic               out_load;
  logic               run_last;
  logic               run_done;
  logic [7:0]         hdr_bytes [FuHdrLen];
  pkt_out_t           cur;

  assign out_load    = !out_valid_q || !out_stall_i;
  assign run_last    = (idx_q == run_q.n_hdr);
  assign run_done    = run_valid_q && out_load && run_last;
  assign run_stall_o = run_valid_q && !run_done;

  always_comb begin
    hdr_bytes[0]  = RtpVersionByte;
    hdr_bytes[1]  = {run_q.marker, payload_type_i};
    hdr_bytes[2]  = run_q.seq[15:8];
    hdr_bytes[3]  = run_q.seq[7:0];
    hdr_bytes[4]  = run_q.stamp[31:24];
    hdr_bytes[5]  = run_q.stamp[23:16];
    hdr_bytes[6]  = run_q.stamp[15:8];
    hdr_bytes[7]  = run_q.stamp[7:0];
    hdr_bytes[8]  = ssrc_i[31:24];
    hdr_bytes[9]  = ssrc_i[23:16];
    hdr_bytes[10] = ssrc_i[15:8];
    hdr_bytes[11] = ssrc_i[7:0];
    hdr_bytes[12] = run_q.fu_ind;
    hdr_bytes[13] = run_q.fu_hdr;
  end

  always_comb begin
    cur.out_byte     = run_last ? run_q.data : hdr_bytes[idx_q];
    cur.packet_start = (idx_q == '0) && (run_q.n_hdr != '0);
    cur.packet_end   = run_last && run_q.pkt_end;
    cur.last_of_run  = run_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (run_valid_i && !run_stall_o) begin
        run_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (run_done) begin
        run_valid_q <= 1'b0;
      end else if (run_valid_q && out_load) begin
        idx_q <= idx_q + RunIdxW'(1);
      end
      if (out_load) begin
        out_valid_q <= run_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (run_valid_i && !run_stall_o) begin
      run_q <= run_i;
    end
    if (out_load && run_valid_q) begin
      out_q <= cur;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/h264_rtp_fua_packetizer_top.sv
`timescale 1ns / 1ps
// H.264 RTP packetizer (single NAL unit and FU-A modes). NAL bytes enter one per transaction
// and RTP packet bytes leave one per transaction through a single output register. A byte
// that opens a packet produces a 12-byte RTP header first (plus FU indicator and FU header
// in FU-A mode), and the input stays stalled until the last byte of that run is loaded into
// the output register; every other byte produces a single output byte, and a dropped NAL
// header byte in FU-A mode produces nothing. Output stalls hold the input as well. Mode and
// fragment size are fixed at the first byte of each NAL; payload type and SSRC are read when
// each header goes out.
module h264_rtp_fua_packetizer_top import h264rtp_pkg::*; #(
  parameter int LEN_WIDTH = LenWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  nal_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pkt_out_t            out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int LenW = LEN_WIDTH;

  logic [6:0]      pt_q;
  logic [31:0]     ssrc_q;
  logic [15:0]     maxp_q;

  logic [15:0]     seq_q, seq_d;
  logic [31:0]     time_q, time_d;
  logic [7:0]      nhdr_q, nhdr_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] off_q, off_d;
  logic [LenW-1:0] cc_q, cc_d;
  logic            frag_q, frag_d;
  logic [15:0]     chunk_q, chunk_d;

  logic            accept;
  logic            go;
  logic [LenW-1:0] len_in;
  logic [LenW-1:0] e_len;
  logic [7:0]      e_hdr;
  logic [31:0]     e_time;
  logic            e_frag;
  logic [15:0]     e_chunk;
  logic [LenW-1:0] e_cc;
  logic [LenW-1:0] pos;
  logic            last_byte;
  logic            last_frag;
  logic            chunk_end;
  logic            run_valid;
  logic            run_stall;
  run_t            run_d;

  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      RegPayloadType: prdata = {25'd0, pt_q};
      RegSsrc:        prdata = ssrc_q;
      RegMaxPayload:  prdata = {16'd0, maxp_q};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q   <= PayloadTypeReset;
      ssrc_q <= SsrcReset;
      maxp_q <= MaxPayloadReset;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        RegPayloadType: pt_q   <= pwdata[6:0];
        RegSsrc:        ssrc_q <= pwdata;
        RegMaxPayload:  maxp_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = run_stall;
  assign accept     = in_valid_i && !in_stall_o;
  assign len_in     = LenW'(in_data_i.nal_length);

  always_comb begin
    seq_d     = seq_q;
    time_d    = time_q;
    nhdr_d    = nhdr_q;
    len_d     = len_q;
    off_d     = off_q;
    cc_d      = cc_q;
    frag_d    = frag_q;
    chunk_d   = chunk_q;
    go        = 1'b0;
    e_len     = len_q;
    e_hdr     = nhdr_q;
    e_time    = time_q;
    e_frag    = frag_q;
    e_chunk   = chunk_q;
    e_cc      = cc_q;
    pos       = off_q;
    last_byte = 1'b0;
    last_frag = 1'b0;
    chunk_end = 1'b0;
    run_valid = 1'b0;
    run_d     = '0;

    if (accept) begin
      if (in_data_i.first_of_nal) begin
        if (len_in == '0) begin
          len_d = '0;
          off_d = '0;
        end else begin
          go      = 1'b1;
          e_len   = len_in;
          e_hdr   = in_data_i.nal_byte;
          e_time  = in_data_i.frame_time;
          e_frag  = 32'(len_in) > 32'(maxp_q);
          e_chunk = (maxp_q < 16'd3) ? 16'd1 : maxp_q - 16'd2;
          e_cc    = '0;
          pos     = '0;
          len_d   = e_len;
          time_d  = e_time;
          nhdr_d  = e_hdr;
          frag_d  = e_frag;
          chunk_d = e_chunk;
          cc_d    = '0;
        end
      end else if (off_q < len_q) begin
        go = 1'b1;
      end
    end

    if (go) begin
      off_d     = pos + LenW'(1);
      last_byte = (pos + LenW'(1)) == e_len;
      run_d.data   = in_data_i.nal_byte;
      run_d.stamp  = e_time;
      run_d.seq    = seq_q;
      if (!e_frag) begin
        run_valid     = 1'b1;
        run_d.marker  = 1'b1;
        run_d.pkt_end = last_byte;
        if (pos == '0) begin
          run_d.n_hdr = RunIdxW'(RtpHdrLen);
          seq_d       = seq_q + 16'd1;
        end
      end else if (pos != '0) begin
        run_valid     = 1'b1;
        last_frag     = 32'(e_len - pos) <= 32'(e_chunk);
        chunk_end     = (32'(e_cc) + 32'd1 >= 32'(e_chunk)) || last_byte;
        run_d.pkt_end = chunk_end;
        cc_d          = chunk_end ? '0 : e_cc + LenW'(1);
        if (e_cc == '0) begin
          run_d.n_hdr  = RunIdxW'(FuHdrLen);
          run_d.marker = last_frag;
          run_d.fu_ind = (e_hdr & NalNriMask) | FuATypeCode;
          run_d.fu_hdr = (e_hdr & NalTypeMask)
                       | ((pos == LenW'(1)) ? FuStartBit : 8'd0)
                       | (last_frag ? FuEndBit : 8'd0);
          seq_d        = seq_q + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= '0;
      time_q  <= '0;
      nhdr_q  <= '0;
      len_q   <= '0;
      off_q   <= '0;
      cc_q    <= '0;
      frag_q  <= 1'b0;
      chunk_q <= '0;
    end else begin
      seq_q   <= seq_d;
      time_q  <= time_d;
      nhdr_q  <= nhdr_d;
      len_q   <= len_d;
      off_q   <= off_d;
      cc_q    <= cc_d;
      frag_q  <= frag_d;
      chunk_q <= chunk_d;
    end
  end

  h264rtp_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .run_valid_i    (run_valid),
    .run_i          (run_d),
    .run_stall_o    (run_stall),
    .payload_type_i (pt_q),
    .ssrc_i         (ssrc_q),
    .out_valid_o    (out_valid_o),
    .out_data_o     (out_data_o),
    .out_stall_i    (out_stall_i)
  );

endmodule

>>> tb/h264_rtp_fua_packetizer_top_tb.sv
`timescale 1ns / 1ps
module h264_rtp_fua_packetizer_top_tb;
  import h264rtp_pkg::*;

  localparam int SettleCycles  = 24;
  localparam int StallLimit    = 4000;
  localparam int HoldCycles    = 300;
  localparam int ItemsPerPhase = 30;
  localparam int NumPhases     = 10;
  localparam int ShowLimit     = 40;

  typedef struct {
    bit          is_reg;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    nal_in_t     item;
    int          runs;
  } step_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  nal_in_t             in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  pkt_out_t            out_data_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Configuration and packetizer state as seen by the predictor.
  logic [6:0]  cfg_pt = PayloadTypeReset;
  logic [31:0] cfg_ssrc = SsrcReset;
  logic [15:0] cfg_maxp = MaxPayloadReset;
  logic [15:0] seq_no = '0;
  logic [31:0] hold_time = '0;
  logic [7:0]  hold_hdr = '0;
  logic [15:0] hold_len = '0;
  logic [15:0] byte_idx = '0;
  logic [15:0] frag_fill = '0;
  logic [15:0] frag_size = '0;
  bit          frag_on = 1'b0;

  pkt_out_t rtp_expected[$];
  int       typed_runs[$];
  step_t    plan[$];

  bit quiet = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  int produced;
  int typed;

  always #4 clk_i = ~clk_i;

  h264_rtp_fua_packetizer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= ShowLimit) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic expect_byte(input logic [7:0] b, input logic s, input logic e);
    pkt_out_t ent;
    ent = '{out_byte: b, packet_start: s, packet_end: e, last_of_run: 1'b0};
    rtp_expected.insert(rtp_expected.size(), ent);
  endtask

  task automatic rtp_header(input logic marker);
    expect_byte(RtpVersionByte, 1'b1, 1'b0);
    expect_byte({marker, cfg_pt}, 1'b0, 1'b0);
    expect_byte(seq_no[15:8], 1'b0, 1'b0);
    expect_byte(seq_no[7:0], 1'b0, 1'b0);
    seq_no = seq_no + 16'd1;
    expect_byte(hold_time[31:24], 1'b0, 1'b0);
    expect_byte(hold_time[23:16], 1'b0, 1'b0);
    expect_byte(hold_time[15:8], 1'b0, 1'b0);
    expect_byte(hold_time[7:0], 1'b0, 1'b0);
    expect_byte(cfg_ssrc[31:24], 1'b0, 1'b0);
    expect_byte(cfg_ssrc[23:16], 1'b0, 1'b0);
    expect_byte(cfg_ssrc[15:8], 1'b0, 1'b0);
    expect_byte(cfg_ssrc[7:0], 1'b0, 1'b0);
  endtask

  task automatic packetize_byte(input nal_in_t it, output int n);
    int         idx;
    int         psize;
    int         p;
    logic       last_frag;
    logic       end_b;
    logic [7:0] fu_hdr;
    n = 0;
    if (it.first_of_nal) begin
      if (it.nal_length == 16'd0) begin
        hold_len = '0;
        byte_idx = '0;
        return;
      end
      hold_len = it.nal_length;
      hold_time = it.frame_time;
      hold_hdr = it.nal_byte;
      byte_idx = '0;
      frag_fill = '0;
      frag_on = it.nal_length > cfg_maxp;
      frag_size = (cfg_maxp < 16'd3) ? 16'd1 : cfg_maxp - 16'd2;
    end else if (byte_idx >= hold_len) begin
      return;
    end
    idx = byte_idx;
    byte_idx = byte_idx + 16'd1;
    if (!frag_on) begin
      if (idx == 0) begin
        rtp_header(1'b1);
        n += 12;
      end
      expect_byte(it.nal_byte, 1'b0, idx + 1 == hold_len);
      n++;
    end else begin
      if (idx == 0) return;
      psize = hold_len - 1;
      p = idx - 1;
      if (frag_fill == 16'd0) begin
        last_frag = (psize - p) <= frag_size;
        fu_hdr = hold_hdr & NalTypeMask;
        if (p == 0) fu_hdr = fu_hdr | FuStartBit;
        if (last_frag) fu_hdr = fu_hdr | FuEndBit;
        rtp_header(last_frag);
        expect_byte((hold_hdr & NalNriMask) | FuATypeCode, 1'b0, 1'b0);
        expect_byte(fu_hdr, 1'b0, 1'b0);
        n += 14;
      end
      end_b = (frag_fill + 1 >= frag_size) || (p + 1 == psize);
      expect_byte(it.nal_byte, 1'b0, end_b);
      n++;
      frag_fill = end_b ? 16'd0 : frag_fill + 16'd1;
    end
    if (n > 0) rtp_expected[rtp_expected.size() - 1].last_of_run = 1'b1;
  endtask

  task automatic check_byte(input pkt_out_t got);
    pkt_out_t want;
    if (rtp_expected.size() == 0) begin
      report($sformatf("unexpected output byte %02h", got.out_byte));
      return;
    end
    want = rtp_expected.pop_front();
    if (got.out_byte !== want.out_byte) begin
      report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
    end
    if (got.packet_start !== want.packet_start) begin
      report($sformatf("packet_start %b, want %b", got.packet_start, want.packet_start));
    end
    if (got.packet_end !== want.packet_end) begin
      report($sformatf("packet_end %b, want %b", got.packet_end, want.packet_end));
    end
    if (got.last_of_run !== want.last_of_run) begin
      report($sformatf("last_of_run %b, want %b", got.last_of_run, want.last_of_run));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        packetize_byte(in_data_i, produced);
        if (typed_runs.size() > 0) begin
          typed = typed_runs.pop_front();
          if (typed >= 0 && typed != produced) begin
            report($sformatf("input byte gave %0d outputs, want %0d", produced, typed));
          end
        end
      end
      if (out_valid_o && !out_stall_i) check_byte(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(99) < 28);
    end
  end

  initial begin
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("h264_rtp_fua_packetizer_top_tb: FAIL");
    $finish;
  end

  task automatic send_nal_byte(input nal_in_t it, input int runs);
    typed_runs.insert(typed_runs.size(), runs);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (rtp_expected.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] back;
    logic [31:0] want;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegPayloadType: cfg_pt = val[6:0];
      RegSsrc:        cfg_ssrc = val;
      RegMaxPayload:  cfg_maxp = val[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    back = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegPayloadType: want = {25'd0, cfg_pt};
      RegSsrc:        want = cfg_ssrc;
      default:        want = {16'd0, cfg_maxp};
    endcase
    if (back !== want) report($sformatf("register %0d reads %08h, want %08h", idx, back, want));
  endtask

  function automatic step_t nal_step(input logic [7:0] b, input logic [15:0] len,
                                     input logic [31:0] stamp, input logic first, input int runs);
    step_t s;
    s.is_reg = 1'b0;
    s.reg_idx = RegPayloadType;
    s.value = '0;
    s.item = '{nal_byte: b, nal_length: len, frame_time: stamp, first_of_nal: first};
    s.runs = runs;
    return s;
  endfunction

  function automatic step_t reg_step(input logic [1:0] idx, input logic [31:0] val);
    step_t s;
    s.is_reg = 1'b1;
    s.reg_idx = idx;
    s.value = val;
    s.item = '0;
    s.runs = -1;
    return s;
  endfunction

  function automatic void add_step(input step_t s);
    plan.insert(plan.size(), s);
  endfunction

  task automatic random_nal(inout int sent);
    nal_in_t it;
    int      len;
    int      keep;
    int      roll;
    int      lo;
    roll = $urandom_range(99);
    if (roll < 6) begin
      it = '{nal_byte: 8'($urandom), nal_length: 16'($urandom), frame_time: $urandom,
             first_of_nal: 1'b0};
      send_nal_byte(it, -1);
      return;
    end
    if (roll < 10) begin
      it = '{nal_byte: 8'($urandom), nal_length: 16'd0, frame_time: $urandom,
             first_of_nal: 1'b1};
      send_nal_byte(it, 0);
      return;
    end
    if (roll < 22 && cfg_maxp <= 16'd40) begin
      lo = (cfg_maxp > 16'd3) ? cfg_maxp - 2 : 1;
      len = $urandom_range(lo, cfg_maxp + 3);
    end else if (roll < 30) begin
      len = $urandom_range(1000, 65535);
    end else begin
      len = $urandom_range(1, 24);
    end
    keep = len;
    if (len > 60) begin
      keep = $urandom_range(1, 12);
    end else if (len > 1 && $urandom_range(99) < 8) begin
      keep = $urandom_range(1, len - 1);
    end
    for (int k = 0; k < keep; k++) begin
      it.nal_byte = 8'($urandom);
      it.first_of_nal = (k == 0);
      it.nal_length = (k == 0) ? 16'(len) : 16'($urandom);
      it.frame_time = $urandom;
      send_nal_byte(it, -1);
      sent++;
    end
  endtask

  initial begin
    int           sent;
    logic [15:0]  maxp_list [NumPhases];
    logic [15:0]  maxp;
    logic [6:0]   pt;
    logic [31:0]  ssrc;
    maxp_list = '{16'd3, 16'd65535, 16'd4, 16'd1200, 16'd5, 16'd0, 16'd8, 16'd14, 16'd0, 16'd6};

    add_step(nal_step(8'h5A, 16'd7, 32'h0, 1'b0, 0));
    add_step(nal_step(8'h65, 16'd0, 32'h1234, 1'b1, 0));
    add_step(nal_step(8'hFF, 16'd1, 32'hFFFF_FFFF, 1'b1, 13));
    add_step(nal_step(8'h00, 16'd3, 32'h0, 1'b1, 13));
    add_step(nal_step(8'hA5, 16'd0, 32'h0, 1'b0, 1));
    add_step(nal_step(8'hFF, 16'd0, 32'h0, 1'b0, 1));
    add_step(nal_step(8'h11, 16'd0, 32'h0, 1'b0, 0));
    add_step(nal_step(8'h41, 16'hFFFF, 32'h8000_0001, 1'b1, 0));
    add_step(nal_step(8'h22, 16'd0, 32'h0, 1'b0, 15));
    add_step(nal_step(8'h33, 16'd0, 32'h0, 1'b0, 1));
    add_step(nal_step(8'h67, 16'd2, 32'h7FFF_FFFE, 1'b1, 13));
    add_step(nal_step(8'h80, 16'd0, 32'h0, 1'b0, 1));
    add_step(reg_step(RegMaxPayload, 32'd3));
    add_step(reg_step(RegPayloadType, 32'd127));
    add_step(reg_step(RegSsrc, 32'hFFFF_FFFF));
    add_step(nal_step(8'h7C, 16'd4, 32'hDEAD_BEEF, 1'b1, 0));
    add_step(nal_step(8'h01, 16'd0, 32'h0, 1'b0, 15));
    add_step(nal_step(8'h02, 16'd0, 32'h0, 1'b0, 15));
    add_step(nal_step(8'hFE, 16'd0, 32'h0, 1'b0, 15));
    add_step(nal_step(8'h65, 16'd3, 32'h0102_0304, 1'b1, 13));
    add_step(nal_step(8'h55, 16'd0, 32'h0, 1'b0, 1));
    add_step(nal_step(8'hAA, 16'd0, 32'h0, 1'b0, 1));
    add_step(reg_step(RegMaxPayload, 32'd65535));
    add_step(reg_step(RegPayloadType, 32'd0));
    add_step(reg_step(RegSsrc, 32'd0));
    add_step(nal_step(8'h06, 16'hFFFF, 32'h0000_FFFF, 1'b1, 13));
    add_step(nal_step(8'h3C, 16'd0, 32'h0, 1'b0, 1));
    add_step(nal_step(8'h09, 16'd1, 32'hFFFF_0000, 1'b1, 13));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        send_nal_byte(plan[i].item, plan[i].runs);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      maxp = (maxp_list[ph] != 16'd0) ? maxp_list[ph] : 16'($urandom_range(3, 30));
      pt = (ph == 0) ? 7'd0 : (ph == 1) ? 7'd127 : 7'($urandom);
      ssrc = (ph == 0) ? 32'd0 : (ph == 1) ? 32'hFFFF_FFFF : $urandom;
      write_reg(RegMaxPayload, {16'd0, maxp});
      write_reg(RegPayloadType, {25'd0, pt});
      write_reg(RegSsrc, ssrc);
      quiet = (ph == 2) || (ph == 3);
      if (ph == 3) hold_req++;
      sent = 0;
      while (sent < ItemsPerPhase) random_nal(sent);
    end
    quiet = 1'b0;

    settle();
    if (mismatches == 0) begin
      $display("h264_rtp_fua_packetizer_top_tb: PASS");
    end else begin
      $display("h264_rtp_fua_packetizer_top_tb: FAIL");
    end
    $finish;
  end

endmodule
